@@ hw/rtl/first_fit_region_allocator_top_assert.svh @@
// Assertion helpers for the region allocator
`ifndef FIRST_FIT_REGION_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define FFRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define FFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ffra_pkg.sv @@
package ffra_pkg;

    // Default configuration
    localparam int FFRA_SLOTS       = 64;
    localparam int FFRA_BLOCK_BYTES = 4096;

    // Address constants
    localparam logic [31:0] KERNEL_START = 32'h0010_0000;
    localparam logic [31:0] KERNEL_SKIP  = 32'h0030_0000;
    localparam logic [31:0] PAGE_MASK    = 32'hFFFF_F000;

    // Operation codes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_ALLOC  = 2'd1;
    localparam logic [1:0] MODE_FREE   = 2'd2;
    localparam logic [1:0] MODE_REMOVE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] base_address;
        logic [31:0] region_size;
        logic [19:0] block_count;
    } t_req;

    typedef struct packed {
        logic [31:0] result_address;
        logic [1:0]  status;
    } t_rsp;

endpackage

@@ hw/rtl/first_fit_region_allocator_top.sv @@
// First-fit free region allocator. Keeps a table of SLOTS free regions (base,
// byte size) in a single-port-read memory and serves one request at a time.
// Add, free and allocate walk the table one slot per cycle through the memory
// read port, with one compare/update unit checking each slot, and stop at the
// first hit or, if none, after the last slot. Remove-last and ignored requests
// skip the scan. After reset the table is cleared one slot per cycle, so the
// block is not ready until the clearing pass ends.
// Results sit in an output register; a new request may be taken while the
// previous result still waits.
`include "first_fit_region_allocator_top_assert.svh"

module first_fit_region_allocator_top
    import ffra_pkg::*;
#(
    parameter int SLOTS       = FFRA_SLOTS,
    parameter int BLOCK_BYTES = FFRA_BLOCK_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int NEED_W = 20 + $clog2(BLOCK_BYTES + 1);
    localparam int CMP_W  = (NEED_W > 32) ? NEED_W : 33;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_chk_idx;
    logic               r_chk_v;
    logic [IDX_W-1:0]   r_last;
    logic [1:0]         r_mode;
    logic [NEED_W-1:0]  r_need;
    logic [31:0]        r_put_base;
    logic [31:0]        r_size;
    t_rsp               r_pend;
    t_rsp               r_rsp;
    logic               r_rsp_valid;

    // Region table, {base, bytes} per slot
    logic [63:0]        mem [SLOTS];
    logic [63:0]        r_rdata;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [63:0]        mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;

    logic [31:0]        rd_base;
    logic [31:0]        rd_bytes;
    logic               rd_empty;
    logic               rd_fit;
    logic               hit;
    logic               last_slot;
    logic [31:0]        need32;
    logic [31:0]        put_bytes;
    logic               accept;

    assign accept      = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Slot check unit
    assign rd_base   = r_rdata[63:32];
    assign rd_bytes  = r_rdata[31:0];
    assign rd_empty  = (rd_base == 32'd0) && (rd_bytes == 32'd0);
    assign rd_fit    = CMP_W'(rd_bytes) >= CMP_W'(r_need);
    assign hit       = (r_mode == MODE_ALLOC) ? (!rd_empty && rd_fit) : rd_empty;
    assign last_slot = (r_chk_idx == IDX_W'(SLOTS - 1));
    assign need32    = 32'(r_need);

    // Byte count stored by add or free; free saturates
    always_comb begin
        if (r_mode == MODE_ADD) begin
            put_bytes = r_size;
        end else if (CMP_W'(r_need) > CMP_W'(32'hFFFF_FFFF)) begin
            put_bytes = 32'hFFFF_FFFF;
        end else begin
            put_bytes = need32;
        end
    end

    // Read address follows the scan counter
    assign mem_raddr = (r_cnt < CNT_W'(SLOTS)) ? r_cnt[IDX_W-1:0] : '0;

    // Table write port: clearing pass, remove, or scan hit
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[IDX_W-1:0];
            end
            S_IDLE: begin
                if (accept && i_req.mode == MODE_REMOVE && r_last != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_last;
                end
            end
            S_SCAN: begin
                if (r_chk_v && hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_chk_idx;
                    if (r_mode == MODE_ALLOC) begin
                        mem_wdata = {rd_base + need32, rd_bytes - need32};
                    end else begin
                        mem_wdata = {r_put_base, put_bytes};
                    end
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Region memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_chk_v     <= 1'b0;
            r_last      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            // output register drains; a result being loaded keeps it full
            if (r_rsp_valid && i_rsp_ready && r_state != S_RESP) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                // wipe the table after reset
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                // take a request
                S_IDLE: begin
                    if (accept) begin
                        r_mode  <= i_req.mode;
                        r_size  <= i_req.region_size;
                        r_need  <= NEED_W'(i_req.block_count) * NEED_W'(BLOCK_BYTES);
                        r_cnt   <= '0;
                        r_chk_v <= 1'b0;
                        if (i_req.base_address == KERNEL_START) begin
                            r_put_base <= (KERNEL_START + KERNEL_SKIP) & PAGE_MASK;
                        end else begin
                            r_put_base <= i_req.base_address;
                        end
                        case (i_req.mode)
                            MODE_FREE: begin
                                if (i_req.block_count == '0 || i_req.base_address == '0) begin
                                    r_pend  <= '{result_address: '0, status: ST_IGNORED};
                                    r_state <= S_RESP;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            MODE_REMOVE: begin
                                r_pend  <= '{result_address: '0,
                                             status: (r_last == '0) ? ST_IGNORED : ST_DONE};
                                r_state <= S_RESP;
                            end
                            default: begin
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                // one slot read issued and one checked per cycle
                S_SCAN: begin
                    if (r_chk_v && hit) begin
                        if (r_mode == MODE_ALLOC) begin
                            r_pend <= '{result_address: rd_base & PAGE_MASK,
                                        status: ST_DONE};
                        end else begin
                            r_pend <= '{result_address: '0, status: ST_DONE};
                            r_last <= r_chk_idx;
                        end
                        r_chk_v <= 1'b0;
                        r_state <= S_RESP;
                    end else if (r_chk_v && last_slot) begin
                        r_pend  <= '{result_address: '0,
                                     status: (r_mode == MODE_ALLOC) ? ST_NOFIT : ST_FULL};
                        r_chk_v <= 1'b0;
                        r_state <= S_RESP;
                    end else if (r_cnt < CNT_W'(SLOTS)) begin
                        r_chk_idx <= r_cnt[IDX_W-1:0];
                        r_chk_v   <= 1'b1;
                        r_cnt     <= r_cnt + 1'b1;
                    end else begin
                        r_chk_v <= 1'b0;
                    end
                end
                // hand the result to the output register
                S_RESP: begin
                    if (!r_rsp_valid || i_rsp_ready) begin
                        r_rsp       <= r_pend;
                        r_rsp_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    `FFRA_ASSERT_NOW(a_clear_not_ready, r_state == S_CLEAR, !o_req_ready, "ready during clear")
    `FFRA_ASSERT_NEXT(a_one_at_a_time, accept, !o_req_ready, "second request taken while busy")
    `FFRA_ASSERT_NOW(a_check_in_scan, r_chk_v, r_state == S_SCAN, "slot check outside scan")

endmodule
